>>> hw/rtl/scaled_round_modular_residue_defines.svh
// Assertion macros shared by the scaled round modular residue RTL.
`ifndef SCALED_ROUND_MODULAR_RESIDUE_DEFINES_SVH
`define SCALED_ROUND_MODULAR_RESIDUE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SRMR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SRMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/srmr_pkg.sv
// Shared types, constants and helpers for the scaled round modular residue block.
`default_nettype none

package srmr_pkg;

  localparam int unsigned DataW   = 64;
  localparam int unsigned ResW    = 63;
  localparam int unsigned ManW    = 53;
  localparam int unsigned ExpW    = 14;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [63:0] ShiftConst = 64'd9223372036854775295;
  localparam logic [63:0] HalfConst  = ShiftConst >> 1;
  localparam logic [62:0] ModReset   = 63'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCALE   = 3'd0,
    CFG_MODULUS = 3'd1,
    CFG_WRAP    = 3'd2,
    CFG_BRATIO  = 3'd3,
    CFG_BSHIFT  = 3'd4
  } cfg_idx_e;

  // operand class after decode
  typedef struct packed {
    logic is_nan;
    logic is_inf;
    logic is_zero;
  } fp_class_t;

  function automatic logic [5:0] lead_zeros53(input logic [52:0] x);
    logic [5:0] n;
    logic       found;
    n     = '0;
    found = 1'b0;
    for (int i = 52; i >= 0; i--) begin
      if (!found) begin
        if (x[i]) found = 1'b1;
        else n = n + 6'd1;
      end
    end
    return n;
  endfunction

  // normalized 53-bit significand with leading one, unbiased exponent
  function automatic logic [ManW+ExpW-1:0] fp_norm(input logic [63:0] b);
    logic [10:0]          e;
    logic [51:0]          f;
    logic [5:0]           lz;
    logic [ManW-1:0]      man;
    logic signed [ExpW-1:0] ex;
    e  = b[62:52];
    f  = b[51:0];
    lz = lead_zeros53({1'b0, f});
    if (e != 11'd0) begin
      man = {1'b1, f};
      ex  = $signed({3'b000, e}) - 14'sd1023;
    end else begin
      man = {1'b0, f} << lz;
      ex  = -14'sd1022 - $signed({8'd0, lz});
    end
    return {man, ex};
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/scaled_round_modular_residue.sv
// Top level: double scale, round to int64, shift and full modular reduction.
`default_nettype none

// Streams IEEE double components and returns one 63-bit residue per component.
// Each sample is multiplied by the scale register as a double (round to
// nearest even), rounded half away from zero to a saturating signed 64-bit
// integer, shifted up by the shift constant when negative, reduced modulo
// limb_modulus and, past half range, corrected by wrap_correction mod m.
// The pipeline takes one transfer per cycle while not stalled and holds 71
// stages: six for the floating multiply and integer conversion, one remainder
// bit per stage for 64 stages (restoring division, with a twin lane reducing
// the correction), and an output register. A stall on the result side freezes
// the whole pipeline, so in_stall_o follows out_stall_i while a result is
// waiting. barrett_ratio and barrett_shift are accepted and have no effect:
// the remainder here is always exact. Configure only when idle.
module scaled_round_modular_residue
  import srmr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [DataW-1:0]    cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [DataW-1:0]    sample_bits_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [ResW-1:0]          residue_o
);

  localparam int unsigned DivN = DataW;

  // ---------------- configuration ----------------
  logic [DataW-1:0] scale_q;
  logic [ResW-1:0]  mod_q;
  logic [ResW-1:0]  wrap_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= '0;
      mod_q   <= ModReset;
      wrap_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SCALE:   scale_q <= cfg_data_i;
        CFG_MODULUS: mod_q   <= cfg_data_i[ResW-1:0];
        CFG_WRAP:    wrap_q  <= cfg_data_i[ResW-1:0];
        CFG_BRATIO:  ;  // exact reduction, reciprocal not needed
        CFG_BSHIFT:  ;
        default:     ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic vld_a_q, vld_b_q, vld_c_q, vld_d_q, vld_e_q, vld_f_q, vld_g_q;
  logic [DivN-1:0] vld_div_q;

  assign en         = !(vld_g_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q   <= 1'b0;
      vld_b_q   <= 1'b0;
      vld_c_q   <= 1'b0;
      vld_d_q   <= 1'b0;
      vld_e_q   <= 1'b0;
      vld_f_q   <= 1'b0;
      vld_div_q <= '0;
      vld_g_q   <= 1'b0;
    end else if (en) begin
      vld_a_q   <= in_valid_i;
      vld_b_q   <= vld_a_q;
      vld_c_q   <= vld_b_q;
      vld_d_q   <= vld_c_q;
      vld_e_q   <= vld_d_q;
      vld_f_q   <= vld_e_q;
      vld_div_q <= {vld_div_q[DivN-2:0], vld_f_q};
      vld_g_q   <= vld_div_q[DivN-1];
    end
  end

  // ---------------- stage A: decode and normalize ----------------
  logic [ManW+ExpW-1:0]   norm_a, norm_b;
  fp_class_t              cls_a, cls_b, cls_d;
  logic                   nan_a, nan_b, inf_a, inf_b, zro_a, zro_b;

  assign norm_a = fp_norm(sample_bits_i);
  assign norm_b = fp_norm(scale_q);
  assign nan_a  = (sample_bits_i[62:52] == 11'h7FF) && (sample_bits_i[51:0] != '0);
  assign nan_b  = (scale_q[62:52] == 11'h7FF) && (scale_q[51:0] != '0);
  assign inf_a  = (sample_bits_i[62:52] == 11'h7FF) && (sample_bits_i[51:0] == '0);
  assign inf_b  = (scale_q[62:52] == 11'h7FF) && (scale_q[51:0] == '0);
  assign zro_a  = (sample_bits_i[62:0] == '0);
  assign zro_b  = (scale_q[62:0] == '0);

  always_comb begin
    cls_d.is_nan  = nan_a || nan_b || (inf_a && zro_b) || (inf_b && zro_a);
    cls_d.is_inf  = (inf_a || inf_b) && !cls_d.is_nan;
    cls_d.is_zero = (zro_a || zro_b) && !cls_d.is_nan;
  end

  fp_class_t              cls_a_q, cls_b_q, cls_c_q, cls_dd_q;
  logic                   neg_a_q, neg_b_q, neg_c_q, neg_d_q;
  logic [ManW-1:0]        man_a_q, man_b_q;
  logic signed [ExpW-1:0] exp_a_q, exp_b_q, exp_c_q;

  assign cls_a = cls_a_q;
  assign cls_b = cls_b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cls_a_q <= cls_d;
      neg_a_q <= sample_bits_i[63] ^ scale_q[63];
      man_a_q <= norm_a[ManW+ExpW-1:ExpW];
      man_b_q <= norm_b[ManW+ExpW-1:ExpW];
      exp_a_q <= $signed(norm_a[ExpW-1:0]) + $signed(norm_b[ExpW-1:0]);
    end
  end

  // ---------------- stage B: partial products (27x27 max) ----------------
  logic [53:0] pp_ll_q;
  logic [52:0] pp_lh_q, pp_hl_q;
  logic [51:0] pp_hh_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp_ll_q <= man_a_q[26:0]  * man_b_q[26:0];
      pp_lh_q <= man_a_q[26:0]  * man_b_q[52:27];
      pp_hl_q <= man_a_q[52:27] * man_b_q[26:0];
      pp_hh_q <= man_a_q[52:27] * man_b_q[52:27];
      cls_b_q <= cls_a;
      neg_b_q <= neg_a_q;
      exp_b_q <= exp_a_q;
    end
  end

  // ---------------- stage C: sum to the 106-bit product ----------------
  logic [105:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q  <= {52'd0, pp_ll_q}
               + ({52'd0, 1'b0, pp_lh_q} << 27)
               + ({52'd0, 1'b0, pp_hl_q} << 27)
               + ({54'd0, pp_hh_q} << 54);
      cls_c_q <= cls_b;
      neg_c_q <= neg_b_q;
      exp_c_q <= exp_b_q;
    end
  end

  // ---------------- stage D: round product to double ----------------
  logic [ManW-1:0]        rd_man;
  logic                   rd_g, rd_s;
  logic [ManW:0]          rd_sum;
  logic [ManW-1:0]        dman_d;
  logic signed [ExpW-1:0] dexp_d;
  logic [ManW-1:0]        dman_q;
  logic signed [ExpW-1:0] dexp_q;

  always_comb begin
    if (prod_q[105]) begin
      rd_man = prod_q[105:53];
      rd_g   = prod_q[52];
      rd_s   = |prod_q[51:0];
      dexp_d = exp_c_q + 14'sd1;
    end else begin
      rd_man = prod_q[104:52];
      rd_g   = prod_q[51];
      rd_s   = |prod_q[50:0];
      dexp_d = exp_c_q;
    end
    rd_sum = {1'b0, rd_man} + {{ManW{1'b0}}, (rd_g && (rd_s || rd_man[0]))};
    if (rd_sum[ManW]) begin
      dman_d = rd_sum[ManW:1];
      dexp_d = dexp_d + 14'sd1;
    end else begin
      dman_d = rd_sum[ManW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dman_q   <= dman_d;
      dexp_q   <= dexp_d;
      cls_dd_q <= cls_c_q;
      neg_d_q  <= neg_c_q;
    end
  end

  // ---------------- stage E: round half away to magnitude ----------------
  logic [63:0] mag_d, mag_q, mw, half_w;
  logic [5:0]  rsh;
  logic [3:0]  lsh;
  logic        neg_e_q;

  assign mw = {11'd0, dman_q};

  always_comb begin
    rsh    = '0;
    lsh    = '0;
    half_w = '0;
    if (cls_dd_q.is_nan) begin
      mag_d = '0;
    end else if (cls_dd_q.is_inf || dexp_q >= 14'sd63) begin
      mag_d = neg_d_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else if (cls_dd_q.is_zero || dexp_q < -14'sd1) begin
      mag_d = '0;
    end else if (dexp_q == -14'sd1) begin
      mag_d = 64'd1;
    end else if (dexp_q <= 14'sd52) begin
      rsh = 6'(14'sd52 - dexp_q);
      if (rsh != 6'd0) half_w = mw >> (rsh - 6'd1);
      mag_d = (mw >> rsh) + {63'd0, (rsh != 6'd0) && half_w[0]};
    end else begin
      lsh   = 4'(dexp_q - 14'sd52);
      mag_d = mw << lsh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q   <= mag_d;
      neg_e_q <= neg_d_q;
    end
  end

  // ---------------- stage F: sign, wrap shift, half-range flag ----------------
  logic [63:0] v_d, v_q;
  logic        corr_q;

  // a negative value plus the shift constant is the constant minus magnitude
  assign v_d = (neg_e_q && mag_q != '0) ? (ShiftConst - mag_q) : mag_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      v_q    <= v_d;
      corr_q <= !v_d[63] && (v_d > HalfConst);
    end
  end

  // ---------------- remainder stages: one bit each ----------------
  logic [ResW-1:0]  rem_q   [DivN];
  logic [ResW-1:0]  wrem_q  [DivN];
  logic [DataW-1:0] dv_q    [DivN];
  logic             dcorr_q [DivN];
  logic [ResW-1:0]  rem_d   [DivN];
  logic [ResW-1:0]  wrem_d  [DivN];
  logic [63:0]      mod_w, wrap_w;
  logic [63:0]      tr, tw;

  assign mod_w  = {1'b0, mod_q};
  assign wrap_w = {1'b0, wrap_q};

  always_comb begin
    for (int j = 0; j < DivN; j++) begin
      if (j == 0) begin
        tr = {63'd0, v_q[DataW-1]};
        tw = {63'd0, wrap_w[DataW-1]};
      end else begin
        tr = {rem_q[j-1], dv_q[j-1][DataW-1-j]};
        tw = {wrem_q[j-1], wrap_w[DataW-1-j]};
      end
      rem_d[j]  = (tr >= mod_w) ? 63'(tr - mod_w) : tr[ResW-1:0];
      wrem_d[j] = (tw >= mod_w) ? 63'(tw - mod_w) : tw[ResW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < DivN; j++) begin
        rem_q[j]  <= rem_d[j];
        wrem_q[j] <= wrem_d[j];
        if (j == 0) begin
          dv_q[j]    <= v_q;
          dcorr_q[j] <= corr_q;
        end else begin
          dv_q[j]    <= dv_q[j-1];
          dcorr_q[j] <= dcorr_q[j-1];
        end
      end
    end
  end

  // ---------------- stage G: correction and output register ----------------
  logic [ResW-1:0] r_fin, d_fin, res_d, res_q;

  assign r_fin = rem_q[DivN-1];
  assign d_fin = wrem_q[DivN-1];

  always_comb begin
    if (mod_q == '0) begin
      res_d = '0;
    end else if (dcorr_q[DivN-1]) begin
      res_d = (r_fin >= d_fin) ? (r_fin - d_fin) : (r_fin + (mod_q - d_fin));
    end else begin
      res_d = r_fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = vld_g_q;
  assign residue_o   = res_q;

  // ---------------- assertions ----------------
`include "scaled_round_modular_residue_defines.svh"

  `SRMR_ASSERT_NEXT(a_accept_enters, in_valid_i && !in_stall_o, vld_a_q, "accepted transfer did not enter the pipeline")
  `SRMR_ASSERT_NOW(a_res_below_mod, out_valid_o && mod_q != '0, residue_o < mod_q, "residue not below the modulus")
  `SRMR_ASSERT_NOW(a_zero_mod, out_valid_o && mod_q == '0, residue_o == '0, "zero modulus must give zero residue")
  `SRMR_ASSERT_NEXT(a_stall_holds, out_valid_o && out_stall_i, out_valid_o && $stable(residue_o), "stalled result changed")

endmodule

`default_nettype wire

>>> tb/tb_scaled_round_modular_residue.sv
// Testbench for scaled_round_modular_residue: directed and random streams against a predictor.
`default_nettype none

module tb_scaled_round_modular_residue;
  import srmr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PipeDepth  = 71;   // stages given at the head of the RTL
  localparam int unsigned DrainWait  = PipeDepth + 10;
  localparam int unsigned StuckLimit = 4000; // cycles with no transfer at all
  localparam logic [63:0] DblOne     = 64'h3FF0_0000_0000_0000;
  localparam logic [62:0] MaxMod     = 63'h7FFF_FFFF_FFFF_FFFF;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [DataW-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [DataW-1:0] sample_bits_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [ResW-1:0]  residue_o;

  // predictor copy of the registers
  logic [63:0] scale_q;
  logic [62:0] modulus_q;
  logic [62:0] wrap_q;

  logic [ResW-1:0] residue_fifo[$];
  int unsigned     mismatches;
  bit              quiet;      // no idling on either side in the closing stretch
  int unsigned     stuck_cnt;

  scaled_round_modular_residue u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_bits_i(sample_bits_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .residue_o    (residue_o)
  );

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  // Round half away from zero to an int64 pattern, saturating; NaN gives 0.
  function automatic logic [63:0] round_to_int64(input real p);
    logic [63:0] pb;
    logic [10:0] ex;
    logic [52:0] man;
    logic [63:0] mag;
    int          sh;
    pb  = $realtobits(p);
    ex  = pb[62:52];
    man = {1'b1, pb[51:0]};
    if (ex == 11'h7FF && pb[51:0] != '0) return '0;
    if (ex >= 11'd1086) return pb[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (ex == '0) return '0;  // subnormal magnitudes are far below one half
    sh = int'(ex) - 1075;
    if (sh >= 0) begin
      mag = 64'(man) << sh;
    end else if (-sh > 53) begin
      mag = '0;
    end else begin
      mag = 64'(man >> (-sh));
      if (((man >> (-sh - 1)) & 53'd1) != '0) mag = mag + 64'd1;
    end
    return pb[63] ? -mag : mag;
  endfunction

  function automatic logic [ResW-1:0] limb_residue(input logic [63:0] sample);
    logic [63:0] v;
    logic [63:0] m;
    logic [63:0] r;
    logic [63:0] d;
    v = round_to_int64($bitstoreal(sample) * $bitstoreal(scale_q));
    if (v[63]) v = v + ShiftConst;
    m = {1'b0, modulus_q};
    if (m == '0) return '0;
    r = v % m;
    // past half range (still non-negative): pull back by the correction mod m
    if (!v[63] && v > HalfConst) begin
      d = {1'b0, wrap_q} % m;
      r = (r >= d) ? r - d : r + (m - d);
    end
    return r[ResW-1:0];
  endfunction

  // Random idle gap a quarter of the time, none when quiet.
  function automatic int unsigned idle_burst();
    if (quiet || $urandom_range(3) != 0) return 0;
    return $urandom_range(10, 1);
  endfunction

  // Result side: random stall bursts.
  int unsigned stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      stall_left  <= idle_burst();
      out_stall_i <= 1'b0;
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    logic [ResW-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (residue_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected residue %h", residue_o);
      end else begin
        want = residue_fifo.pop_front();
        if (want !== residue_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("residue mismatch: expected %h actual %h", want, residue_o);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cnt <= 0;
    end else if (stuck_cnt >= StuckLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stuck_cnt <= stuck_cnt + 1;
    end
  end

  task automatic send_sample(input logic [63:0] bits);
    int unsigned gap;
    sample_bits_i <= bits;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    residue_fifo.push_back(limb_residue(bits));
    gap = idle_burst();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (residue_fifo.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Register write; only called with the pipeline drained.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SCALE:   scale_q   = data;
      CFG_MODULUS: modulus_q = data[62:0];
      CFG_WRAP:    wrap_q    = data[62:0];
      default: ;  // Barrett values and unknown indexes leave the residue alone
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_limb(input logic [63:0] scale, input logic [62:0] m,
                           input logic [62:0] wrap);
    write_reg(CFG_SCALE, scale);
    write_reg(CFG_MODULUS, {1'($urandom_range(1)), m});
    write_reg(CFG_WRAP, {1'($urandom_range(1)), wrap});
    write_reg(CFG_BRATIO, {$urandom, $urandom});
    write_reg(CFG_BSHIFT, {$urandom, $urandom});
  endtask

  function automatic logic [62:0] rand63();
    return 63'({$urandom, $urandom});
  endfunction

  // Double of either sign with magnitude from 2^-3 up to just under 2^65.
  function automatic logic [63:0] plain_sample();
    logic [10:0] ex;
    ex = 11'($urandom_range(1023 + 64, 1023 - 3));
    return {1'($urandom_range(1)), ex, 20'($urandom), $urandom};
  endfunction

  function automatic logic [63:0] mixed_sample();
    if ($urandom_range(4) == 0) return {$urandom, $urandom};  // raw bits, all classes
    return plain_sample();
  endfunction

  // Reset values: scale 0 makes every product 0 or NaN.
  task automatic test_reset_state();
    send_sample(DblOne);
    send_sample(64'h7FF0_0000_0000_0000);
    send_sample(64'hC340_0000_0000_0001);
    drain();
  endtask

  // Rounding, saturation, NaN, infinities and the half-range edges at scale 1.
  task automatic test_directed_edges();
    load_limb(DblOne, 63'd1_000_000_007, 63'd123_456_789_012);
    send_sample($realtobits(0.5));
    send_sample($realtobits(-0.5));
    send_sample($realtobits(1.5));
    send_sample($realtobits(-2.5));
    send_sample($realtobits(0.49999999999999994));
    send_sample(64'h8000_0000_0000_0000);          // negative zero
    send_sample(64'h0000_0000_0000_0001);          // smallest subnormal
    send_sample(64'h7FF8_0000_0000_0000);          // quiet NaN
    send_sample(64'hFFF0_0000_0000_0001);          // signaling NaN, sign set
    send_sample(64'h7FF0_0000_0000_0000);          // +inf saturates high
    send_sample(64'hFFF0_0000_0000_0000);          // -inf saturates low
    send_sample(64'h7FEF_FFFF_FFFF_FFFF);          // largest finite
    send_sample(64'hC3E0_0000_0000_0000);          // -2^63, stays negative after shift
    send_sample(64'h43CF_FFFF_FFFF_FFFF);          // just under 2^62, still below half range
    send_sample(64'h43D0_0000_0000_0000);          // 2^62
    send_sample(64'hC3D0_0000_0000_0000);          // -2^62
    send_sample(64'h43E0_0000_0000_0000);          // 2^63 saturates
    drain();
  endtask

  // Largest modulus with an equal correction, then modulus 0, the reset modulus, unknown indexes.
  task automatic test_modulus_extremes();
    load_limb(64'h4330_0000_0000_0000, MaxMod, MaxMod);   // scale 2^52
    repeat (60) send_sample(mixed_sample());
    drain();
    load_limb(DblOne, 63'd0, rand63());
    repeat (30) send_sample(mixed_sample());
    drain();
    load_limb(64'h3FE0_0000_0000_0000, 63'd2, 63'd5);
    repeat (30) send_sample(mixed_sample());
    drain();
    write_reg(3'd5, {$urandom, $urandom});   // unknown indexes are dropped
    write_reg(3'd6, {$urandom, $urandom});
    write_reg(3'd7, {$urandom, $urandom});
    repeat (20) send_sample(mixed_sample());
    drain();
  endtask

  // Eight limbs with random moduli and scales from 2^-20 to 2^60, the last fully random.
  task automatic test_random_limbs();
    logic [63:0] scale;
    for (int limb = 0; limb < 8; limb++) begin
      scale = {1'b0, 11'($urandom_range(1023 + 60, 1023 - 20)), 20'($urandom), $urandom};
      if (limb == 7) scale = {$urandom, $urandom};
      load_limb(scale, rand63() >> $urandom_range(60), rand63());
      repeat (170) send_sample(mixed_sample());
      drain();
    end
  endtask

  // Back-to-back stream with no idling on either side.
  task automatic test_full_rate();
    load_limb(DblOne, MaxMod - 63'd24, rand63());
    quiet = 1'b1;
    repeat (250) send_sample(mixed_sample());
    drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_SCALE;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    sample_bits_i = '0;
    mismatches    = 0;
    quiet         = 1'b0;
    stuck_cnt     = 0;
    scale_q       = '0;
    modulus_q     = ModReset;
    wrap_q        = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_directed_edges();
    test_modulus_extremes();
    test_random_limbs();
    test_full_rate();

    if (mismatches == 0 && residue_fifo.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> scaled_round_modular_residue.f
+incdir+hw/rtl
hw/rtl/srmr_pkg.sv
hw/rtl/scaled_round_modular_residue.sv
tb/tb_scaled_round_modular_residue.sv
